// File: design/dtp_pkg.sv
// Shared types and constants for the date-time string parser.
package dtp_pkg;

   localparam int ACC_W   = 14;
   localparam int SMALL_W = 7;
   localparam int COUNT_W = 3;

   localparam logic [7:0] CHAR_DASH  = 8'h2d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0d;

   localparam logic [COUNT_W-1:0] YEAR_MAX_CHARS  = 3'd4;
   localparam logic [COUNT_W-1:0] FIELD_MAX_CHARS = 3'd2;

   localparam logic [ACC_W-1:0]   YEAR_BASE  = 14'd1900;
   localparam logic [SMALL_W-1:0] MONTH_MAX  = 7'd12;
   localparam logic [SMALL_W-1:0] DAY_MAX    = 7'd31;
   localparam logic [SMALL_W-1:0] HOUR_MAX   = 7'd23;
   localparam logic [SMALL_W-1:0] MINUTE_MAX = 7'd59;

   typedef enum logic [2:0] {
      FIELD_YEAR,
      FIELD_MONTH,
      FIELD_DAY,
      FIELD_HOUR,
      FIELD_MINUTE,
      FIELD_SECOND
   } field_type;

   typedef enum logic [1:0] {
      PHASE_BLANK,
      PHASE_DIGITS,
      PHASE_DONE
   } phase_type;

   typedef struct packed {
      logic       last_char;
      logic       is_digit;
      logic [3:0] digit;
      logic       is_blank;
      logic       is_plus;
      logic       is_dash;
      logic       is_space;
      logic       is_colon;
   } char_item_type;

   typedef struct packed {
      logic        valid_res;
      logic [12:0] years_since_1900;
      logic [3:0]  month_index;
      logic [4:0]  day_of_month;
      logic [4:0]  hour_value;
      logic [5:0]  minute_value;
      logic [5:0]  second_value;
   } rsp_item_type;

endpackage

// File: design/dtp_req_if.sv
// Character input channel: valid/ready plus one character and end flag.
interface dtp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_char;
   logic       final_char;

   modport source (output valid, output text_char, output final_char, input ready);
   modport sink   (input valid, input text_char, input final_char, output ready);
endinterface

// File: design/dtp_rsp_if.sv
// Result channel: valid/ready plus the broken-down time.
interface dtp_rsp_if;
   logic        valid;
   logic        ready;
   logic        valid_res;
   logic [12:0] years_since_1900;
   logic [3:0]  month_index;
   logic [4:0]  day_of_month;
   logic [4:0]  hour_value;
   logic [5:0]  minute_value;
   logic [5:0]  second_value;

   modport source (output valid, output valid_res, output years_since_1900,
                   output month_index, output day_of_month, output hour_value,
                   output minute_value, output second_value, input ready);
   modport sink   (input valid, input valid_res, input years_since_1900,
                   input month_index, input day_of_month, input hour_value,
                   input minute_value, input second_value, output ready);
endinterface

// File: design/dtp_front.sv
// Front end: classifies each character and queues it in a two-entry FIFO.
module dtp_front (
   input  logic                   clock,
   input  logic                   reset,
   dtp_req_if.sink                req,
   output dtp_pkg::char_item_type item,
   output logic                   item_valid,
   input  logic                   item_pop
);
   import dtp_pkg::*;

   char_item_type mem_ff [2];
   char_item_type cls;
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          push;
   logic          pop;

   always_comb begin
      cls.last_char = req.final_char;
      cls.is_digit  = (req.text_char >= CHAR_ZERO) && (req.text_char <= CHAR_NINE);
      cls.digit     = req.text_char[3:0];
      cls.is_blank  = (req.text_char == CHAR_SPACE) ||
                      ((req.text_char >= CHAR_TAB) && (req.text_char <= CHAR_CR));
      cls.is_plus   = (req.text_char == CHAR_PLUS);
      cls.is_dash   = (req.text_char == CHAR_DASH);
      cls.is_space  = (req.text_char == CHAR_SPACE);
      cls.is_colon  = (req.text_char == CHAR_COLON);
   end

   assign req.ready  = (count_ff != 2'd2);
   assign push       = req.valid && req.ready;
   assign item_valid = (count_ff != 2'd0);
   assign pop        = item_pop && item_valid;
   assign item       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// File: design/dtp_back.sv
// Back end: field parser, range checks and result register.
module dtp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  dtp_pkg::char_item_type item,
   input  logic                   item_valid,
   output logic                   item_pop,
   dtp_rsp_if.source              rsp
);
   import dtp_pkg::*;

   field_type           field_ff, field_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   phase_type           phase_ff, phase_in;
   logic                neg_ff, neg_in;
   logic                err_ff, err_in;
   logic [ACC_W-1:0]    year_ff, year_in;
   logic                year_neg_ff, year_neg_in;
   logic [SMALL_W-1:0]  mon_ff, mon_in, day_ff, day_in, hour_ff, hour_in, min_ff, min_in;
   logic                mon_neg_ff, mon_neg_in, day_neg_ff, day_neg_in;
   logic                hour_neg_ff, hour_neg_in, min_neg_ff, min_neg_in;
   logic                out_valid_ff, out_valid_in;
   rsp_item_type        out_ff, out_in;

   logic                has_sep;
   logic [COUNT_W-1:0]  limit;
   logic [ACC_W-1:0]    acc_x10;
   logic                ok;
   logic [ACC_W-1:0]    year_off;
   logic [SMALL_W-1:0]  mon_dec;

   // only a final character has to wait for the result register
   assign item_pop = item_valid && (!item.last_char || !out_valid_ff || rsp.ready);
   assign acc_x10  = {acc_ff[ACC_W-4:0], 3'b000} + {acc_ff[ACC_W-2:0], 1'b0};

   always_comb begin
      unique case (field_ff)
         FIELD_YEAR, FIELD_MONTH: has_sep = item.is_dash;
         FIELD_DAY:               has_sep = item.is_space;
         FIELD_HOUR, FIELD_MINUTE: has_sep = item.is_colon;
         default:                 has_sep = 1'b0;
      endcase
      limit = (field_ff == FIELD_YEAR) ? YEAR_MAX_CHARS : FIELD_MAX_CHARS;
   end

   always_comb begin
      field_in    = field_ff;
      count_in    = count_ff;
      acc_in      = acc_ff;
      phase_in    = phase_ff;
      neg_in      = neg_ff;
      err_in      = err_ff;
      year_in     = year_ff;
      year_neg_in = year_neg_ff;
      mon_in      = mon_ff;
      mon_neg_in  = mon_neg_ff;
      day_in      = day_ff;
      day_neg_in  = day_neg_ff;
      hour_in     = hour_ff;
      hour_neg_in = hour_neg_ff;
      min_in      = min_ff;
      min_neg_in  = min_neg_ff;

      if (item_pop && !err_ff) begin
         if (has_sep) begin
            unique case (field_ff)
               FIELD_YEAR: begin
                  year_in     = acc_ff;
                  year_neg_in = neg_ff;
                  field_in    = FIELD_MONTH;
               end
               FIELD_MONTH: begin
                  mon_in     = acc_ff[SMALL_W-1:0];
                  mon_neg_in = neg_ff;
                  field_in   = FIELD_DAY;
               end
               FIELD_DAY: begin
                  day_in     = acc_ff[SMALL_W-1:0];
                  day_neg_in = neg_ff;
                  field_in   = FIELD_HOUR;
               end
               FIELD_HOUR: begin
                  hour_in     = acc_ff[SMALL_W-1:0];
                  hour_neg_in = neg_ff;
                  field_in    = FIELD_MINUTE;
               end
               default: begin
                  min_in     = acc_ff[SMALL_W-1:0];
                  min_neg_in = neg_ff;
                  field_in   = FIELD_SECOND;
               end
            endcase
            count_in = '0;
            acc_in   = '0;
            phase_in = PHASE_BLANK;
            neg_in   = 1'b0;
         end else if (count_ff >= limit) begin
            err_in = 1'b1;
         end else begin
            count_in = count_ff + 3'd1;
            if (phase_ff == PHASE_BLANK && item.is_blank) begin
               phase_in = PHASE_BLANK;
            end else if (phase_ff == PHASE_BLANK && (item.is_plus || item.is_dash)) begin
               neg_in   = item.is_dash;
               phase_in = PHASE_DIGITS;
            end else if (phase_ff != PHASE_DONE && item.is_digit) begin
               acc_in   = acc_x10 + {{(ACC_W-4){1'b0}}, item.digit};
               phase_in = PHASE_DIGITS;
            end else begin
               phase_in = PHASE_DONE;
            end
         end
      end
   end

   always_comb begin
      ok = !err_in && (field_in == FIELD_SECOND) &&
           !year_neg_in && (year_in >= YEAR_BASE) &&
           !mon_neg_in && (mon_in != '0) && (mon_in <= MONTH_MAX) &&
           !day_neg_in && (day_in != '0) && (day_in <= DAY_MAX) &&
           (hour_in <= HOUR_MAX) && (!hour_neg_in || hour_in == '0) &&
           (min_in <= MINUTE_MAX) && (!min_neg_in || min_in == '0) &&
           (acc_in <= {{(ACC_W-SMALL_W){1'b0}}, MINUTE_MAX}) &&
           (!neg_in || acc_in == '0);
      year_off = year_in - YEAR_BASE;
      mon_dec  = mon_in - 7'd1;

      out_in = '0;
      if (ok) begin
         out_in.valid_res        = 1'b1;
         out_in.years_since_1900 = year_off[12:0];
         out_in.month_index      = mon_dec[3:0];
         out_in.day_of_month     = day_in[4:0];
         out_in.hour_value       = hour_in[4:0];
         out_in.minute_value     = min_in[5:0];
         out_in.second_value     = acc_in[5:0];
      end

      if (item_pop && item.last_char) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (item_pop && item.last_char)) begin
         field_ff    <= FIELD_YEAR;
         count_ff    <= '0;
         acc_ff      <= '0;
         phase_ff    <= PHASE_BLANK;
         neg_ff      <= 1'b0;
         err_ff      <= 1'b0;
         year_ff     <= '0;
         year_neg_ff <= 1'b0;
         mon_ff      <= '0;
         mon_neg_ff  <= 1'b0;
         day_ff      <= '0;
         day_neg_ff  <= 1'b0;
         hour_ff     <= '0;
         hour_neg_ff <= 1'b0;
         min_ff      <= '0;
         min_neg_ff  <= 1'b0;
      end else begin
         field_ff    <= field_in;
         count_ff    <= count_in;
         acc_ff      <= acc_in;
         phase_ff    <= phase_in;
         neg_ff      <= neg_in;
         err_ff      <= err_in;
         year_ff     <= year_in;
         year_neg_ff <= year_neg_in;
         mon_ff      <= mon_in;
         mon_neg_ff  <= mon_neg_in;
         day_ff      <= day_in;
         day_neg_ff  <= day_neg_in;
         hour_ff     <= hour_in;
         hour_neg_ff <= hour_neg_in;
         min_ff      <= min_in;
         min_neg_ff  <= min_neg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop && item.last_char) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.valid_res        = out_ff.valid_res;
   assign rsp.years_since_1900 = out_ff.years_since_1900;
   assign rsp.month_index      = out_ff.month_index;
   assign rsp.day_of_month     = out_ff.day_of_month;
   assign rsp.hour_value       = out_ff.hour_value;
   assign rsp.minute_value     = out_ff.minute_value;
   assign rsp.second_value     = out_ff.second_value;

endmodule

// File: design/datetime_string_parser.sv
// Top level of the date-time string parser.
//
//   channel    port       dir  payload
//   ---------  ---------  ---  --------------------------------------------
//   request    req_port   in   text_char[7:0], final_char
//   response   rsp_port   out  valid_res, years_since_1900 .. second_value
//
// One character per cycle is sustained unless a held response stalls it;
// the final character passes the FIFO stage, then the result register.
// A held response stalls only the next final character; the request side
// stalls once that character and one more fill the two-entry FIFO.
// Synchronous reset clears the FIFO, the parse state and the response valid.
module datetime_string_parser (
   input  logic      clock,
   input  logic      reset,
   dtp_req_if.sink   req_port,
   dtp_rsp_if.source rsp_port
);
   import dtp_pkg::*;

   char_item_type item;
   logic          item_valid;
   logic          item_pop;

   dtp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_port),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop)
   );

   dtp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .rsp        (rsp_port)
   );

endmodule

// File: verif/dtp_result_checker.sv
// Passive checker: watches both channels, predicts each parse result and compares it.
module dtp_result_checker (
   input  logic clock,
   input  logic reset,
   dtp_req_if   req_mon,
   dtp_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   pending_count,
   output int   result_count,
   output int   valid_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import dtp_pkg::*;

   field_type          fld;
   logic [COUNT_W-1:0] char_cnt;
   logic [ACC_W-1:0]   acc;
   phase_type          phase;
   logic               neg;
   logic               err;
   int                 sv_year, sv_month, sv_day, sv_hour, sv_minute;

   rsp_item_type       pending_times[$];

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic clear_field();
      char_cnt = '0;
      acc      = '0;
      phase    = PHASE_BLANK;
      neg      = 1'b0;
   endtask

   task automatic clear_parse();
      fld       = FIELD_YEAR;
      clear_field();
      sv_year   = 0;
      sv_month  = 0;
      sv_day    = 0;
      sv_hour   = 0;
      sv_minute = 0;
      err       = 1'b0;
   endtask

   function automatic int signed_field();
      int m;
      m = int'(acc);
      return neg ? -m : m;
   endfunction

   task automatic scan_char(input logic [7:0] c);
      logic is_digit;
      logic is_blank;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      is_blank = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
      if (phase == PHASE_BLANK && is_blank) begin
         // leading blank, skipped
      end else if (phase == PHASE_BLANK && (c == CHAR_PLUS || c == CHAR_DASH)) begin
         neg   = (c == CHAR_DASH);
         phase = PHASE_DIGITS;
      end else if (phase != PHASE_DONE && is_digit) begin
         acc   = ACC_W'(acc * 10 + (c - CHAR_ZERO));
         phase = PHASE_DIGITS;
      end else begin
         phase = PHASE_DONE;
      end
   endtask

   task automatic close_field();
      int v;
      v = signed_field();
      case (fld)
         FIELD_YEAR:  sv_year  = v;
         FIELD_MONTH: sv_month = v;
         FIELD_DAY:   sv_day   = v;
         FIELD_HOUR:  sv_hour  = v;
         default:     sv_minute = v;
      endcase
      fld = field_type'(fld + 3'd1);
      clear_field();
   endtask

   task automatic parse_char(input logic [7:0] c, input logic fin);
      logic [7:0]         sep;
      logic               has_sep;
      logic [COUNT_W-1:0] cap;
      int                 sec;
      logic               ok;
      rsp_item_type       r;
      if (!err) begin
         has_sep = 1'b1;
         case (fld)
            FIELD_YEAR, FIELD_MONTH:  sep = CHAR_DASH;
            FIELD_DAY:                sep = CHAR_SPACE;
            FIELD_HOUR, FIELD_MINUTE: sep = CHAR_COLON;
            default: begin
               sep     = 8'h00;
               has_sep = 1'b0;
            end
         endcase
         if (has_sep && c == sep) begin
            close_field();
         end else begin
            cap = (fld == FIELD_YEAR) ? YEAR_MAX_CHARS : FIELD_MAX_CHARS;
            if (char_cnt >= cap) begin
               err = 1'b1;
            end else begin
               char_cnt++;
               scan_char(c);
            end
         end
      end
      if (fin) begin
         sec = signed_field();
         ok  = !err && fld == FIELD_SECOND &&
               sv_year >= int'(YEAR_BASE) &&
               sv_month >= 1 && sv_month <= int'(MONTH_MAX) &&
               sv_day >= 1 && sv_day <= int'(DAY_MAX) &&
               sv_hour >= 0 && sv_hour <= int'(HOUR_MAX) &&
               sv_minute >= 0 && sv_minute <= int'(MINUTE_MAX) &&
               sec >= 0 && sec <= int'(MINUTE_MAX);
         r = '0;
         if (ok) begin
            r.valid_res        = 1'b1;
            r.years_since_1900 = 13'(sv_year - int'(YEAR_BASE));
            r.month_index      = 4'(sv_month - 1);
            r.day_of_month     = 5'(sv_day);
            r.hour_value       = 5'(sv_hour);
            r.minute_value     = 6'(sv_minute);
            r.second_value     = 6'(sec);
         end
         pending_times = {pending_times, r};
         clear_parse();
      end
   endtask

   task automatic check_result();
      rsp_item_type want;
      if (pending_times.size() == 0) begin
         report_mismatch("result transfer with no string pending");
      end else begin
         want = pending_times.pop_front();
         result_count++;
         if (want.valid_res)
            valid_count++;
         if (rsp_mon.valid_res !== want.valid_res)
            report_mismatch($sformatf("valid_res got %0d want %0d",
                                      rsp_mon.valid_res, want.valid_res));
         if (rsp_mon.years_since_1900 !== want.years_since_1900)
            report_mismatch($sformatf("years_since_1900 got %0d want %0d",
                                      rsp_mon.years_since_1900, want.years_since_1900));
         if (rsp_mon.month_index !== want.month_index)
            report_mismatch($sformatf("month_index got %0d want %0d",
                                      rsp_mon.month_index, want.month_index));
         if (rsp_mon.day_of_month !== want.day_of_month)
            report_mismatch($sformatf("day_of_month got %0d want %0d",
                                      rsp_mon.day_of_month, want.day_of_month));
         if (rsp_mon.hour_value !== want.hour_value)
            report_mismatch($sformatf("hour_value got %0d want %0d",
                                      rsp_mon.hour_value, want.hour_value));
         if (rsp_mon.minute_value !== want.minute_value)
            report_mismatch($sformatf("minute_value got %0d want %0d",
                                      rsp_mon.minute_value, want.minute_value));
         if (rsp_mon.second_value !== want.second_value)
            report_mismatch($sformatf("second_value got %0d want %0d",
                                      rsp_mon.second_value, want.second_value));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parse();
         pending_times.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            parse_char(req_mon.text_char, req_mon.final_char);
         if (rsp_mon.valid && rsp_mon.ready)
            check_result();
      end
      pending_count = pending_times.size();
   end

endmodule

// File: verif/datetime_string_parser_tb.sv
// Testbench top: clock, reset, character stimulus, response back-pressure and verdict.
module datetime_string_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dtp_pkg::*;

   typedef logic [7:0] char_q_type[$];

   localparam int LONG_HOLD    = 300;
   localparam int PHASE_CHARS  = 200;
   localparam int DRAIN_CYCLES = 20;

   logic clock;
   logic reset;
   int   idle_pct;
   int   stall_pct;
   int   hold_token;
   int   chars_sent;
   int   mismatch_count;
   int   pending_count;
   int   result_count;
   int   valid_count;

   dtp_req_if req_bus ();
   dtp_rsp_if rsp_bus ();

   datetime_string_parser DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   dtp_result_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .result_count   (result_count),
      .valid_count    (valid_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #400_000;
      $display("tb: failure");
      $finish;
   end

   // response side: random stall, or a long hold-off when requested
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   task automatic send_char(input logic [7:0] c, input logic fin);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.text_char  <= c;
      req_bus.final_char <= fin;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_text(input string s, input bit close);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], close && (i == s.len() - 1));
   endtask

   task automatic send_bytes(input char_q_type q);
      foreach (q[i])
         send_char(q[i], i == q.size() - 1);
   endtask

   // wait until every expected result has been transferred
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   function automatic char_q_type field_text(input int cap, input int lo, input int hi,
                                             input bit in_range);
      char_q_type q;
      string      s;
      int         pick;
      int         top;
      int         n;
      top  = (cap == 4) ? 9999 : 99;
      pick = in_range ? $urandom_range(0, 59) : $urandom_range(0, 99);
      s    = "";
      if (pick < 60) begin
         s = $sformatf("%0d", $urandom_range(lo, hi));
         if (s.len() < cap && $urandom_range(0, 1))
            s = {"0", s};
         else if (s.len() < cap && $urandom_range(0, 3) == 0)
            s = {"+", s};
      end else if (pick < 68) begin
         s = $sformatf("%0d", $urandom_range(0, top));
      end else if (pick < 74) begin
         s = {($urandom_range(0, 1) ? "-" : "+"), $sformatf("%0d", $urandom_range(0, top / 10))};
      end else if (pick < 80) begin
         q = {q, 8'($urandom_range(CHAR_TAB, CHAR_CR))};
         s = $sformatf("%0d", $urandom_range(0, top / 10));
      end else if (pick < 86) begin
         s = "";
      end else if (pick < 92) begin
         s = $sformatf("%0d", $urandom_range(top + 1, top * 10 + 9));
      end else begin
         n = $urandom_range(1, cap);
         repeat (n) q = {q, 8'($urandom_range(0, 255))};
      end
      for (int i = 0; i < s.len(); i++)
         q = {q, 8'(s[i])};
      return q;
   endfunction

   task automatic send_random_string();
      char_q_type q;
      int         kind;
      int         n;
      int         lo_v[6] = '{1900, 1, 1, 0, 0, 0};
      int         hi_v[6] = '{9999, 12, 31, 23, 59, 59};
      logic [7:0] seps[5] = '{CHAR_DASH, CHAR_DASH, CHAR_SPACE, CHAR_COLON, CHAR_COLON};
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         n = $urandom_range(1, 24);
         repeat (n) q = {q, 8'($urandom_range(0, 255))};
      end else begin
         for (int f = 0; f < 6; f++) begin
            q = {q, field_text((f == 0) ? 4 : 2, lo_v[f], hi_v[f], kind < 50)};
            if (f < 5) begin
               if ($urandom_range(0, 99) < 3)
                  q = {q, 8'($urandom_range(0, 255))};
               else
                  q = {q, seps[f]};
            end
         end
         if (kind >= 90) begin
            n = $urandom_range(1, q.size());
            q = q[0:n-1];
         end
      end
      send_bytes(q);
   endtask

   initial begin
      int target;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.text_char  <= 8'h00;
      req_bus.final_char <= 1'b0;
      idle_pct   = 0;
      stall_pct  = 0;
      hold_token = 0;
      chars_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_text("1900-1-1 0:0:0", 1);
      send_text("9999-12-31 23:59:59", 1);
      send_text("1899-1-1 0:0:0", 1);
      send_text("20001-1-1 1:1:1", 1);
      send_text("2000-123", 1);
      send_text("7", 1);
      send_text("2000-1-1 1:1:", 1);
      send_text("2000-1-1 -0:-0:-0", 1);
      send_text("2000-1", 0);
      send_char(8'h00, 1'b0);
      send_text("-1 1:1:1", 1);
      send_text("2000-1-1 1:1:-:", 1);
      send_text("2000- 5-\t9 +1:1: 5", 1);
      send_text("---::", 1);
      send_text("2000-13-32 24:60:60", 1);
      settle();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 64; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 64; end
            default: begin idle_pct = 37; stall_pct = 37; end
         endcase
         target = chars_sent + PHASE_CHARS;
         while (chars_sent < target)
            send_random_string();
         if (p == 2) begin
            hold_token++;
            repeat (4) send_random_string();
         end
         settle();
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("summary: %0d characters sent, %0d parse results checked (%0d valid dates)",
               chars_sent, result_count, valid_count);
      $display("summary: idle/stall mixes none, sender, receiver, both; one long response hold");
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
